@@ hw/rtl/fcce_pkg.sv @@
// Package with shared types and constants of the cluster chain engine.
`default_nettype none
package fcce_pkg;
  localparam int unsigned TableEntries = 4096;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam logic [27:0] EntryEoc = 28'hFFFFFFF;
  localparam logic [27:0] EocLow = 28'hFFFFFF8;
  localparam logic [11:0] CountMax = 12'hFFF;
  localparam logic [11:0] TotalReset = 12'd4094;
  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_ALLOC = 2'd2,
    MODE_FREE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef struct packed {
    mode_e       mode;
    logic [27:0] cluster;
    logic [31:0] value;
    logic        link_prev;
    logic        in_table;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [27:0] result_cluster;
    logic [27:0] entry_value;
    logic [11:0] freed_count;
  } rsp_t;
endpackage
`default_nettype wire

@@ hw/rtl/fat_cluster_chain_engine.sv @@
// Top level of the FAT32 cluster chain engine.
`default_nettype none
// The engine keeps a 4096-entry allocation table; each s_axis transfer runs one
// operation, which yields exactly one m_axis transfer. cfg_we_i writes the cluster
// count; the user must do this only while the block is idle; it is not enforced.
// A front queue of two entries accepts operations while the back sequencer
// works, so an upstream source sees no stall until the queue fills.
// Allocate scans the entries one after another, and free chain walks the chain
// member by member. The table has a write port and a separate registered read
// port, so one entry can be written while another is read.
// After reset the sequencer clears the table, one entry a cycle, through all 4096
// entries; operations are queued but not executed until it finishes.
// When the receiver stalls, the result register holds its transfer and the
// sequencer waits; the queue then fills and s_axis_tready falls.
module fat_cluster_chain_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [11:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: mode[1:0], cluster[29:2], value[61:30], link_prev[62], zero [63]
  input  wire logic [63:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: status[1:0], result_cluster[29:2], entry_value[57:30],
  // freed_count[69:58], zero [71:70]
  output logic [71:0]      m_axis_tdata
);
  logic [11:0]    total_q;
  logic           cmd_valid, cmd_ready, busy;
  fcce_pkg::cmd_t cmd;
  fcce_pkg::rsp_t rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= fcce_pkg::TotalReset;
    end else if (cfg_we_i) begin
      total_q <= cfg_wdata_i;
    end
  end

  fcce_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .mode_i     (s_axis_tdata[1:0]),
    .cluster_i  (s_axis_tdata[29:2]),
    .value_i    (s_axis_tdata[61:30]),
    .link_prev_i(s_axis_tdata[62]),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  fcce_back u_back (
    .clk_i, .rst_ni,
    .total_i    (total_q),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .rsp_valid_o(m_axis_tvalid),
    .rsp_ready_i(m_axis_tready),
    .rsp_o      (rsp),
    .busy_o     (busy)
  );

  assign m_axis_tdata = {2'b00, rsp.freed_count, rsp.entry_value,
                         rsp.result_cluster, rsp.status};

  // A command is taken from the queue only when the sequencer is idle.
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready) |-> !busy) else $error("command taken while busy");
  // Disk full never reports a cluster.
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && rsp.status == fcce_pkg::ST_FULL) |-> (rsp.result_cluster == '0))
    else $error("full status with cluster");
  // Freed count only comes with free chain results, never with an entry read.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (rsp.freed_count == '0 || rsp.entry_value == '0))
    else $error("mixed result fields");
endmodule
`default_nettype wire

@@ hw/rtl/fcce_front.sv @@
// Front end: accepts operations, decodes them and queues them for the engine.
`default_nettype none
module fcce_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [1:0]     mode_i,
  input  wire logic [27:0]    cluster_i,
  input  wire logic [31:0]    value_i,
  input  wire logic           link_prev_i,
  output logic                cmd_valid_o,
  input  wire logic           cmd_ready_i,
  output fcce_pkg::cmd_t      cmd_o
);
  fcce_pkg::cmd_t q_mem [fcce_pkg::QDepth];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  fcce_pkg::cmd_t cmd_in;

  always_comb begin
    cmd_in.mode      = fcce_pkg::mode_e'(mode_i);
    cmd_in.cluster   = cluster_i;
    cmd_in.value     = value_i;
    cmd_in.link_prev = link_prev_i;
    cmd_in.in_table  = (cluster_i[27:fcce_pkg::IdxW] == '0);
  end

  assign in_ready_o  = (cnt_q != 2'(fcce_pkg::QDepth));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem[rd_ptr_q];
  assign wr_ptr_d    = push ? ~wr_ptr_q : wr_ptr_q;
  assign rd_ptr_d    = pop ? ~rd_ptr_q : rd_ptr_q;
  assign cnt_d       = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/fcce_back.sv @@
// Back end: table memory, clearing pass, and the sequencer that runs each operation.
`default_nettype none
module fcce_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [11:0]    total_i,
  input  wire logic           cmd_valid_i,
  output logic                cmd_ready_o,
  input  fcce_pkg::cmd_t      cmd_i,
  output logic                rsp_valid_o,
  input  wire logic           rsp_ready_i,
  output fcce_pkg::rsp_t      rsp_o,
  output logic                busy_o
);
  localparam int unsigned IdxW = fcce_pkg::IdxW;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RDWT  = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_LINK  = 7'b0010000,
    S_FREE  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_e;

  state_e         state_q, state_d;
  logic [31:0]    mem [fcce_pkg::TableEntries];
  logic [31:0]    rdata_q;
  logic           we;
  logic [IdxW-1:0] waddr, raddr;
  logic [31:0]    wdata;
  logic [IdxW-1:0] ptr_q, ptr_d;
  logic [27:0]    cl_q, cl_d;
  logic           link_q, link_d;
  logic [27:0]    found_q, found_d;
  logic [12:0]    limit;
  fcce_pkg::rsp_t rsp_q, rsp_d;
  logic           rsp_v_q, rsp_v_d;
  logic [27:0]    nxt;

  assign limit = {1'b0, total_i} + 13'd2;
  assign nxt   = rdata_q[27:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    cl_d    = cl_q;
    link_d  = link_q;
    found_d = found_q;
    rsp_d   = rsp_q;
    rsp_v_d = rsp_v_q;
    we      = 1'b0;
    waddr   = ptr_q;
    wdata   = '0;
    raddr   = ptr_q;
    cmd_ready_o = 1'b0;
    if (rsp_v_q && rsp_ready_i) begin
      rsp_v_d = 1'b0;
    end
    case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        // The result register doubles as the working result, so a new
        // operation starts only once it is empty or being emptied.
        cmd_ready_o = !rsp_v_q || rsp_ready_i;
        raddr = cmd_i.cluster[IdxW-1:0];
        if (cmd_valid_i && cmd_ready_o) begin
          rsp_d   = '0;
          cl_d    = cmd_i.cluster;
          link_d  = cmd_i.link_prev;
          ptr_d   = cmd_i.cluster[IdxW-1:0];
          case (cmd_i.mode)
            fcce_pkg::MODE_READ: begin
              state_d = cmd_i.in_table ? S_RDWT : S_RESP;
            end
            fcce_pkg::MODE_WRITE: begin
              we    = cmd_i.in_table;
              waddr = cmd_i.cluster[IdxW-1:0];
              wdata = cmd_i.value;
              state_d = S_RESP;
            end
            fcce_pkg::MODE_ALLOC: begin
              ptr_d   = IdxW'(2);
              raddr   = IdxW'(2);
              state_d = S_SCAN;
            end
            default: begin
              if (cmd_i.cluster >= fcce_pkg::EocLow || cmd_i.cluster == '0) begin
                state_d = S_RESP;
              end else if (cmd_i.cluster < 28'd2 || !cmd_i.in_table ||
                           {15'd0, limit} <= cmd_i.cluster) begin
                rsp_d.status = fcce_pkg::ST_INVALID;
                state_d = S_RESP;
              end else begin
                state_d = S_FREE;
              end
            end
          endcase
        end
      end
      S_RDWT: begin
        rsp_d.entry_value = rdata_q[27:0];
        state_d = S_RESP;
      end
      S_SCAN: begin
        // rdata_q holds entry ptr_q; stop at the configured limit or table end.
        if ({1'b0, ptr_q} >= limit) begin
          rsp_d.status = fcce_pkg::ST_FULL;
          state_d = S_RESP;
        end else if (nxt == '0) begin
          found_d = 28'(ptr_q);
          rsp_d.result_cluster = 28'(ptr_q);
          state_d = S_LINK;
        end else if (ptr_q == '1) begin
          rsp_d.status = fcce_pkg::ST_FULL;
          state_d = S_RESP;
        end else begin
          ptr_d = ptr_q + 1'b1;
          raddr = ptr_q + 1'b1;
        end
      end
      S_LINK: begin
        if (link_q) begin
          we    = (cl_q[27:IdxW] == '0);
          waddr = cl_q[IdxW-1:0];
          wdata = {4'd0, found_q};
          link_d = 1'b0;
        end else begin
          we    = 1'b1;
          waddr = found_q[IdxW-1:0];
          wdata = {4'd0, fcce_pkg::EntryEoc};
          state_d = S_RESP;
        end
      end
      S_FREE: begin
        // rdata_q holds entry of ptr_q, a valid chain member.
        we    = 1'b1;
        waddr = ptr_q;
        wdata = '0;
        if (rsp_q.freed_count != fcce_pkg::CountMax) begin
          rsp_d.freed_count = rsp_q.freed_count + 12'd1;
        end
        ptr_d = nxt[IdxW-1:0];
        raddr = nxt[IdxW-1:0];
        if (nxt >= fcce_pkg::EocLow || nxt == '0) begin
          state_d = S_RESP;
        end else if (nxt < 28'd2 || nxt[27:IdxW] != '0 || {15'd0, limit} <= nxt) begin
          rsp_d.status = fcce_pkg::ST_INVALID;
          state_d = S_RESP;
        end else if (nxt[IdxW-1:0] == ptr_q) begin
          // Self loop: the entry just zeroed would be read once more as zero,
          // so it is counted again here and the walk ends.
          if (rsp_d.freed_count != fcce_pkg::CountMax) begin
            rsp_d.freed_count = rsp_d.freed_count + 12'd1;
          end
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!rsp_v_q || rsp_ready_i) begin
          rsp_v_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ptr_q   <= '0;
      rsp_v_q <= 1'b0;
      link_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      rsp_v_q <= rsp_v_d;
      link_q  <= link_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cl_q    <= cl_d;
    found_q <= found_d;
    rsp_q   <= rsp_d;
  end

  assign rsp_valid_o = rsp_v_q;
  assign rsp_o       = rsp_q;
  assign busy_o      = (state_q != S_IDLE);
endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the FAT32 cluster chain engine.
`timescale 1ns / 1ps

// Scoreboard: keeps its own copy of the allocation table and the cluster
// count, works out the response of each accepted operation, and checks
// responses in order against it.
class fat_scoreboard;
  logic [31:0] fat_copy [fcce_pkg::TableEntries];
  logic [11:0] cluster_count;
  fcce_pkg::rsp_t pending_rsps[$];
  int unsigned errors;
  int unsigned rsps_checked;
  int unsigned mode_seen [4];
  int unsigned full_seen;
  int unsigned invalid_seen;

  function new();
    foreach (fat_copy[i]) fat_copy[i] = '0;
    cluster_count = fcce_pkg::TotalReset;
    errors = 0;
    rsps_checked = 0;
    full_seen = 0;
    invalid_seen = 0;
    foreach (mode_seen[i]) mode_seen[i] = 0;
  endfunction

  // First free cluster that an allocate would pick now, 0 when none.
  function int unsigned first_free();
    int unsigned lim;
    lim = int'(cluster_count) + 2;
    for (int unsigned i = 2; i < lim && i < fcce_pkg::TableEntries; i++) begin
      if (fat_copy[i][27:0] == 28'd0) return i;
    end
    return 0;
  endfunction

  // Applies one accepted operation to the table copy and queues its response.
  function void note_op(fcce_pkg::mode_e mode, logic [27:0] cluster,
                        logic [31:0] value, logic link_prev);
    fcce_pkg::rsp_t rsp;
    int unsigned lim;
    int unsigned found;
    logic [27:0] walk;
    logic [27:0] nxt;
    rsp = '0;
    rsp.status = fcce_pkg::ST_OK;
    lim = int'(cluster_count) + 2;
    mode_seen[mode]++;
    case (mode)
      fcce_pkg::MODE_READ: begin
        if (cluster < fcce_pkg::TableEntries) rsp.entry_value = fat_copy[cluster][27:0];
      end
      fcce_pkg::MODE_WRITE: begin
        if (cluster < fcce_pkg::TableEntries) fat_copy[cluster] = value;
      end
      fcce_pkg::MODE_ALLOC: begin
        found = first_free();
        if (found == 0) begin
          rsp.status = fcce_pkg::ST_FULL;
          full_seen++;
        end else begin
          // The link goes in first, so a tail equal to the new cluster ends
          // up as end of chain.
          if (link_prev && cluster < fcce_pkg::TableEntries) fat_copy[cluster] = found;
          fat_copy[found] = {4'h0, fcce_pkg::EntryEoc};
          rsp.result_cluster = found[27:0];
        end
      end
      default: begin
        walk = cluster;
        while (walk < fcce_pkg::EocLow && walk != 28'd0) begin
          if (walk < 2 || walk >= lim || walk >= fcce_pkg::TableEntries) begin
            rsp.status = fcce_pkg::ST_INVALID;
            invalid_seen++;
            break;
          end
          nxt = fat_copy[walk][27:0];
          fat_copy[walk] = '0;
          walk = nxt;
          if (rsp.freed_count != fcce_pkg::CountMax) rsp.freed_count++;
        end
      end
    endcase
    pending_rsps.push_back(rsp);
  endfunction

  // Compares one delivered response with the oldest pending one.
  function void check_rsp(fcce_pkg::rsp_t got);
    fcce_pkg::rsp_t want;
    rsps_checked++;
    if (pending_rsps.size() == 0) begin
      $error("response with none pending: status %0d", got.status);
      errors++;
      return;
    end
    want = pending_rsps.pop_front();
    if (got.status != want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      errors++;
    end
    if (got.result_cluster != want.result_cluster) begin
      $error("result_cluster: expected %0d, got %0d", want.result_cluster,
             got.result_cluster);
      errors++;
    end
    if (got.entry_value != want.entry_value) begin
      $error("entry_value: expected %h, got %h", want.entry_value, got.entry_value);
      errors++;
    end
    if (got.freed_count != want.freed_count) begin
      $error("freed_count: expected %0d, got %0d", want.freed_count, got.freed_count);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int unsigned CycleLimit = 20000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [11:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  fat_scoreboard sb = new();

  // Idle and stall rates in percent, set per phase by the stimulus process.
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  // Toggling this asks the response side for a long hold-off.
  bit          hold_req = 1'b0;
  bit          hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int unsigned ops_sent = 0;

  always #5 clk_i = ~clk_i;

  fat_cluster_chain_engine dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Response side: checks each transfer and drives tready, stalling at the
  // phase rate or holding off entirely for a long stretch when asked.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      sb.check_rsp(fcce_pkg::rsp_t'({m_axis_tdata[1:0], m_axis_tdata[29:2],
                                     m_axis_tdata[57:30], m_axis_tdata[69:58]}));
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog for a hung block.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAIL fat_cluster_chain_engine");
      $finish;
    end
  end

  // Offers one operation and returns once its transfer is accepted. tvalid
  // stays high into the next call unless that call idles first.
  task automatic send_op(fcce_pkg::mode_e mode, logic [27:0] cluster, logic [31:0] value,
                         logic link_prev);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, link_prev, value, cluster, mode};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_op(mode, cluster, value, link_prev);
    ops_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_rsps.size() != 0) @(posedge clk_i);
  endtask

  // Writes the cluster count; only called with nothing in flight.
  task automatic set_total(logic [11:0] total);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= total;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.cluster_count = total;
  endtask

  // Random operation aimed mostly at clusters near the valid range, with
  // values that build chains, end markers, or arbitrary bit patterns.
  task automatic rand_op();
    int unsigned pick;
    int unsigned span;
    logic [27:0] cluster;
    logic [31:0] value;
    fcce_pkg::mode_e mode;
    span = int'(sb.cluster_count) + 3;
    pick = $urandom_range(99);
    if (pick < 80) cluster = 28'($urandom_range(span));
    else if (pick < 90) cluster = 28'($urandom);
    else cluster = 28'($urandom_range(4097, 4094));
    pick = $urandom_range(99);
    if (pick < 50) value = {4'($urandom_range(15)), 28'($urandom_range(span))};
    else if (pick < 70) value = {4'($urandom_range(15)),
                                 28'($urandom_range(32'h0FFFFFFF, 32'h0FFFFFF8))};
    else value = $urandom;
    pick = $urandom_range(99);
    if (pick < 25) mode = fcce_pkg::MODE_READ;
    else if (pick < 55) mode = fcce_pkg::MODE_WRITE;
    else if (pick < 80) mode = fcce_pkg::MODE_ALLOC;
    else mode = fcce_pkg::MODE_FREE;
    send_op(mode, cluster, value, 1'($urandom_range(1)));
  endtask

  task automatic run_phase(logic [11:0] total, int unsigned idle, int unsigned stall,
                           int unsigned count, bit pressure);
    set_total(total);
    idle_pct  = idle;
    stall_pct = stall;
    if (pressure) hold_req = ~hold_req;
    repeat (count) rand_op();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the full cluster range.
    set_total(12'd4094);
    send_op(fcce_pkg::MODE_READ, 28'd2, 32'd0, 1'b0);
    send_op(fcce_pkg::MODE_WRITE, 28'd2, 32'hFFFFFFFF, 1'b1);
    send_op(fcce_pkg::MODE_READ, 28'd2, 32'd0, 1'b0);
    // Entries beyond the table: the write is dropped and the read answers zero.
    send_op(fcce_pkg::MODE_WRITE, 28'hFFFFFFF, 32'd1, 1'b0);
    send_op(fcce_pkg::MODE_READ, 28'hFFFFFFF, 32'd0, 1'b0);
    send_op(fcce_pkg::MODE_READ, 28'd4095, 32'd0, 1'b0);
    send_op(fcce_pkg::MODE_WRITE, 28'd2, 32'd0, 1'b0);
    send_op(fcce_pkg::MODE_ALLOC, 28'd0, 32'd0, 1'b0);
    send_op(fcce_pkg::MODE_ALLOC, 28'd2, 32'd0, 1'b1);
    drain();
    // Tail cluster equal to the cluster the allocate is about to pick.
    send_op(fcce_pkg::MODE_ALLOC, 28'(sb.first_free()), 32'd0, 1'b1);
    send_op(fcce_pkg::MODE_FREE, 28'd2, 32'd0, 1'b0);
    send_op(fcce_pkg::MODE_FREE, 28'd0, 32'd0, 1'b0);
    send_op(fcce_pkg::MODE_FREE, 28'hFFFFFF8, 32'd0, 1'b0);
    send_op(fcce_pkg::MODE_FREE, 28'd1, 32'd0, 1'b0);
    // A two-entry loop, freed from one end.
    send_op(fcce_pkg::MODE_WRITE, 28'd5, 32'd6, 1'b0);
    send_op(fcce_pkg::MODE_WRITE, 28'd6, 32'd5, 1'b0);
    send_op(fcce_pkg::MODE_FREE, 28'd5, 32'd0, 1'b0);
    // An entry that points at itself.
    send_op(fcce_pkg::MODE_WRITE, 28'd8, 32'd8, 1'b0);
    send_op(fcce_pkg::MODE_FREE, 28'd8, 32'd0, 1'b0);
    // A chain that leaves the valid range partway.
    send_op(fcce_pkg::MODE_WRITE, 28'd7, 32'd9000, 1'b0);
    send_op(fcce_pkg::MODE_FREE, 28'd7, 32'd0, 1'b0);
    send_op(fcce_pkg::MODE_FREE, 28'd4095, 32'd0, 1'b0);
    // No clusters at all: allocate finds nothing.
    set_total(12'd0);
    send_op(fcce_pkg::MODE_ALLOC, 28'd3, 32'd0, 1'b1);
    send_op(fcce_pkg::MODE_FREE, 28'd2, 32'd0, 1'b0);
    // Largest count reaches past the table; the scan stops at its end.
    set_total(12'd4095);
    send_op(fcce_pkg::MODE_FREE, 28'd4095, 32'd0, 1'b0);
    send_op(fcce_pkg::MODE_ALLOC, 28'd4095, 32'd0, 1'b1);

    // Random part over several counts and handshake rates.
    run_phase(12'd4094, 0, 0, 60, 1'b0);
    run_phase(12'd16, 48, 0, 100, 1'b0);
    run_phase(12'd24, 0, 48, 100, 1'b0);
    run_phase(12'd40, 21, 21, 100, 1'b0);
    run_phase(12'd8, 0, 0, 60, 1'b1);
    run_phase(12'd4095, 48, 48, 30, 1'b0);
    run_phase(12'd1, 21, 21, 30, 1'b0);

    drain();
    repeat (50) @(posedge clk_i);
    $display("Covered %0d operations (read %0d, write %0d, allocate %0d, free %0d),",
             ops_sent, sb.mode_seen[0], sb.mode_seen[1], sb.mode_seen[2], sb.mode_seen[3]);
    $display("%0d responses checked, %0d disk-full and %0d invalid-chain outcomes.",
             sb.rsps_checked, sb.full_seen, sb.invalid_seen);
    if (sb.errors == 0 && sb.pending_rsps.size() == 0) begin
      $display("PASS fat_cluster_chain_engine");
    end else begin
      $display("FAIL fat_cluster_chain_engine");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hw/rtl/fcce_pkg.sv
hw/rtl/fcce_front.sv
hw/rtl/fcce_back.sv
hw/rtl/fat_cluster_chain_engine.sv
tb/sv/tb_top.sv
